@@ rtl/srcm_pkg.sv @@
// shared types, widths and fixed matrix coefficients for the split-region colour matrix
// no dependencies

package srcm_pkg;

  localparam int COUNT_BITS     = 24;
  localparam int COEF_FRAC_BITS = 10;
  localparam int SPLIT_BITS     = 24;
  localparam int PIX_BITS       = 8;
  localparam int QUEUE_DEPTH    = 4;

  localparam int CMP_BITS  = (COUNT_BITS > SPLIT_BITS) ? COUNT_BITS : SPLIT_BITS;
  localparam int COEF_BITS = COEF_FRAC_BITS + 1;
  localparam int PROD_BITS = PIX_BITS + COEF_BITS;
  localparam int SUM_BITS  = PROD_BITS + 2;
  localparam int SHR_BITS  = SUM_BITS - COEF_FRAC_BITS;

  localparam logic [SPLIT_BITS-1:0] SPLIT_RESET = SPLIT_BITS'(153600);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = {COUNT_BITS{1'b1}};
  localparam logic [PIX_BITS-1:0]   PIX_MAX     = {PIX_BITS{1'b1}};

  localparam int MAT_SEPIA = 0;
  localparam int MAT_ICY   = 1;

  // thousandths, [matrix][out channel][in channel]
  localparam int MILLI_COEF [2][3][3] = '{
    '{'{393, 769, 189}, '{349, 686, 168}, '{272, 534, 131}},
    '{'{600,   0, 200}, '{  0, 700, 200}, '{200, 200, 1300}}
  };

  typedef logic [PIX_BITS-1:0] pix_t;

  typedef struct packed {
    logic icy;
    pix_t blue;
    pix_t green;
    pix_t red;
  } item_t;

  // round half up to the fixed-point grid
  function automatic logic [COEF_BITS-1:0] fixed_coef(int milli);
    return COEF_BITS'(((milli << COEF_FRAC_BITS) + 500) / 1000);
  endfunction

endpackage

@@ rtl/split_region_color_matrix_core.sv @@
// top level of the split-region colour matrix: front end, item queue and matrix back end
// depends on srcm_pkg, srcm_front, srcm_queue, srcm_back
//
// One RGB pixel per item in raster order, one item per clock sustained while m_tready is
// high. Pixels whose index since the last frame start (tuser high) is below split_point
// get a sepia matrix, the rest an icy-blue matrix; each channel is the truncated weighted
// sum saturated at 255. After the input accept the item passes the queue write, then the
// product register and the output register, which drives m_tvalid. The pixel counter
// saturates at its maximum until the next frame start. split_point resets to 153600 and is
// written through cfg_wr_en / cfg_wr_data.

module split_region_color_matrix_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [23:0] cfg_wr_data,  // split_point
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,      // red_in, green_in, blue_in
  input  logic        s_tuser,      // frame_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,      // red_out, green_out, blue_out
  output logic        m_tuser       // region_icy
);
  import srcm_pkg::*;

  logic  push;
  logic  queue_full;
  item_t push_item;
  logic  pop;
  logic  not_empty;
  item_t pop_item;
  pix_t  red_out;
  pix_t  green_out;
  pix_t  blue_out;

  srcm_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_tvalid),
    .frame_start (s_tuser),
    .red_in      (s_tdata[7:0]),
    .green_in    (s_tdata[15:8]),
    .blue_in     (s_tdata[23:16]),
    .push        (push),
    .queue_full  (queue_full),
    .push_item   (push_item),
    .in_ready    (s_tready)
  );

  srcm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (not_empty),
    .pop_item  (pop_item)
  );

  srcm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (not_empty),
    .item       (pop_item),
    .item_take  (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .region_icy (m_tuser)
  );

  assign m_tdata = {blue_out, green_out, red_out};

endmodule

@@ rtl/srcm_front.sv @@
// front end: pixel counter, split register and region classification
// depends on srcm_pkg

module srcm_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [srcm_pkg::SPLIT_BITS-1:0] cfg_wr_data,
  input  logic                           in_valid,
  input  logic                           frame_start,
  input  srcm_pkg::pix_t                 red_in,
  input  srcm_pkg::pix_t                 green_in,
  input  srcm_pkg::pix_t                 blue_in,
  output logic                           push,
  input  logic                           queue_full,
  output srcm_pkg::item_t                push_item,
  output logic                           in_ready
);
  import srcm_pkg::*;

  logic [SPLIT_BITS-1:0] split_point;
  logic [COUNT_BITS-1:0] pixel_count;
  logic [COUNT_BITS-1:0] pixel_count_next;
  logic [COUNT_BITS-1:0] idx;
  logic                  icy;

  assign in_ready = !queue_full;
  assign push     = in_valid && !queue_full;

  assign idx = frame_start ? '0 : pixel_count;
  assign icy = !(CMP_BITS'(idx) < CMP_BITS'(split_point));
  assign pixel_count_next = (idx == COUNT_MAX) ? idx : idx + COUNT_BITS'(1);

  assign push_item.icy   = icy;
  assign push_item.red   = red_in;
  assign push_item.green = green_in;
  assign push_item.blue  = blue_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      split_point <= SPLIT_RESET;
    end else if (cfg_wr_en) begin
      split_point <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count <= '0;
    end else if (push) begin
      pixel_count <= pixel_count_next;
    end
  end

endmodule

@@ rtl/srcm_queue.sv @@
// short item queue between front end and matrix back end
// depends on srcm_pkg

module srcm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  srcm_pkg::item_t push_item,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output srcm_pkg::item_t pop_item
);
  import srcm_pkg::*;

  localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  item_t               entries [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wr_ptr;
  logic [PTR_BITS-1:0] rd_ptr;
  logic [CNT_BITS-1:0] fill;
  logic                do_push;
  logic                do_pop;

  assign full      = (fill == CNT_BITS'(QUEUE_DEPTH));
  assign not_empty = (fill != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CNT_BITS'(1);
      end
    end
  end

endmodule

@@ rtl/srcm_back.sv @@
// back end: two-stage 3x3 matrix multiply (product register, then truncation, saturation and output register)
// depends on srcm_pkg

module srcm_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  input  srcm_pkg::item_t item,
  output logic            item_take,
  output logic            out_valid,
  input  logic            out_ready,
  output srcm_pkg::pix_t  red_out,
  output srcm_pkg::pix_t  green_out,
  output srcm_pkg::pix_t  blue_out,
  output logic            region_icy
);
  import srcm_pkg::*;

  logic [COEF_BITS-1:0] coef_sepia [3][3];
  logic [COEF_BITS-1:0] coef_icy   [3][3];

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign coef_sepia[r][c] = fixed_coef(MILLI_COEF[MAT_SEPIA][r][c]);
      assign coef_icy[r][c]   = fixed_coef(MILLI_COEF[MAT_ICY][r][c]);
    end
  end

  pix_t                 px [3];
  logic [PROD_BITS-1:0] prod_next [3][3];
  logic [PROD_BITS-1:0] prod      [3][3];
  logic                 s1_valid;
  logic                 s1_icy;
  logic                 s1_en;
  logic                 s2_en;
  logic [SUM_BITS-1:0]  sum [3];
  logic [SHR_BITS-1:0]  shr [3];
  pix_t                 chan_next [3];
  pix_t                 chan      [3];

  assign px[0] = item.red;
  assign px[1] = item.green;
  assign px[2] = item.blue;

  assign s2_en     = !out_valid || out_ready;
  assign s1_en     = !s1_valid || s2_en;
  assign item_take = s1_en && item_valid;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_next[r][c] = PROD_BITS'(px[c]) *
                          PROD_BITS'(item.icy ? coef_icy[r][c] : coef_sepia[r][c]);
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = SUM_BITS'(prod[r][0]) + SUM_BITS'(prod[r][1]) + SUM_BITS'(prod[r][2]);
      shr[r] = sum[r][SUM_BITS-1:COEF_FRAC_BITS];
      chan_next[r] = (shr[r] > SHR_BITS'(PIX_MAX)) ? PIX_MAX : shr[r][PIX_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      prod   <= prod_next;
      s1_icy <= item.icy;
    end
    if (s2_en) begin
      chan       <= chan_next;
      region_icy <= s1_icy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= item_valid;
      end
      if (s2_en) begin
        out_valid <= s1_valid;
      end
    end
  end

  assign red_out   = chan[0];
  assign green_out = chan[1];
  assign blue_out  = chan[2];

endmodule
